// ----- rtl/core/i85x_pkg.sv -----
// ----------------------------------------------------------------------------
// i85x_pkg
// Shared types, codes and flag helpers for the 8085 execute unit.
// ----------------------------------------------------------------------------
package i85x_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [2:0] RC_M = 3'd6;
    localparam logic [2:0] RC_A = 3'd7;

    localparam logic [7:0] OP_NOP = 8'h00;
    localparam logic [7:0] OP_RIM = 8'h20;
    localparam logic [7:0] OP_SIM = 8'h30;
    localparam logic [7:0] OP_HLT = 8'h76;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  opcode;
        logic [7:0]  operand_low;
        logic [7:0]  operand_high;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [7:0]  reg_d;
        logic [7:0]  reg_e;
        logic [7:0]  reg_h;
        logic [7:0]  reg_l;
        logic [15:0] stack_pointer;
        logic [7:0]  read_data;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    // Sign, zero and even-parity bits in their flag positions.
    function automatic logic [7:0] f_szp(input logic [7:0] v);
        f_szp = {v[7], (v == 8'h00), 3'b000, ~^v, 2'b00};
    endfunction

    // Returns {new value, new flags}; carry is kept.
    function automatic logic [15:0] f_incdec(input logic [7:0] r, input logic down,
                                             input logic cy);
        logic [7:0] v;
        logic       ac;
        if (down) begin
            v  = r - 8'd1;
            ac = (r[3:0] != 4'h0);
        end else begin
            v  = r + 8'd1;
            ac = (r[3:0] == 4'hF);
        end
        f_incdec = {v, f_szp(v) | {3'b000, ac, 3'b000, cy}};
    endfunction

    // Returns {new accumulator, new flags}.
    function automatic logic [15:0] f_daa(input logic [7:0] a, input logic [7:0] f);
        logic [8:0] t;
        logic       ac;
        logic       cy;
        t  = {1'b0, a};
        ac = 1'b0;
        cy = f[0];
        if (a[3:0] > 4'd9 || f[4]) begin
            ac = (a[3:0] > 4'd9);
            t  = t + 9'd6;
            if (t[8]) cy = 1'b1;
            t[8] = 1'b0;
        end
        if (t[7:4] > 4'd9 || cy) begin
            t = t + 9'h060;
            if (t[8]) cy = 1'b1;
        end
        f_daa = {t[7:0], f_szp(t[7:0]) | {3'b000, ac, 3'b000, cy}};
    endfunction

endpackage

// ----- rtl/core/i85x_mem.sv -----
// ----------------------------------------------------------------------------
// i85x_mem
// Single-port byte memory with a registered read port.
// ----------------------------------------------------------------------------
module i85x_mem
    import i85x_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/i8085_instruction_execute_unit.sv -----
// ----------------------------------------------------------------------------
// i8085_instruction_execute_unit
// Executes one 8085 instruction (0x00-0x7F) or one host memory access per item.
// ----------------------------------------------------------------------------
// Register-only instructions and all single memory writes finish in S_IDLE, so
// such items can follow each other every clock while the result is taken. Items
// that read the memory (host read, MOV r,M, LDAX, LDA, INR M, DCR M) also pass
// S_RD, SHLD passes S_WR2 and LHLD S_RD and S_RD2, since every access goes
// through the one port of the byte memory and its read data is registered. The
// memory holds MEM_BYTES bytes (a power of two); addresses wrap to that size. A
// new item is taken only while the output register is empty or being read out.
module i8085_instruction_execute_unit
    import i85x_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_RD2, S_WR2} t_state;
    typedef enum logic [1:0] {K_HOST, K_REG, K_INR, K_LHLD} t_kind;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   r_dec, n_dec;
    logic [2:0] r_dst, n_dst;
    logic [MEM_AW-1:0] r_addr2, n_addr2;
    logic [7:0] r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [7:0] n_a, n_f, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [15:0] r_sp, n_sp;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    t_mem_req   mreq;
    logic [7:0] rdata;
    logic       accept, out_load, w_en;
    logic [2:0] w_code;
    logic [7:0] w_val, rd_val;
    logic [1:0] status;

    i85x_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    function automatic logic [7:0] get8(input logic [2:0] k);
        unique case (k)
            3'd0:    get8 = r_b;
            3'd1:    get8 = r_c;
            3'd2:    get8 = r_d;
            3'd3:    get8 = r_e;
            3'd4:    get8 = r_h;
            3'd5:    get8 = r_l;
            RC_A:    get8 = r_a;
            default: get8 = 8'h00;
        endcase
    endfunction

    function automatic logic [15:0] get_pair(input logic [1:0] p);
        unique case (p)
            2'd0:    get_pair = {r_b, r_c};
            2'd1:    get_pair = {r_d, r_e};
            2'd2:    get_pair = {r_h, r_l};
            default: get_pair = r_sp;
        endcase
    endfunction

    always_comb begin
        logic [7:0]  op;
        logic [1:0]  p;
        logic [2:0]  dst;
        logic [15:0] imm, pv, hl, res16;
        logic [16:0] sum;
        op  = i_in_item.opcode;
        p   = op[5:4];
        dst = op[5:3];
        imm = {i_in_item.operand_high, i_in_item.operand_low};
        hl  = {r_h, r_l};
        pv  = get_pair(p);
        sum = '0;
        res16 = '0;

        n_state = r_state;
        n_kind  = r_kind;
        n_dec   = r_dec;
        n_dst   = r_dst;
        n_addr2 = r_addr2;
        n_a = r_a; n_f = r_f; n_b = r_b; n_c = r_c;
        n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l; n_sp = r_sp;
        mreq     = '0;
        out_load = 1'b0;
        status   = ST_OK;
        rd_val   = 8'h00;
        w_en     = 1'b0;
        w_code   = dst;
        w_val    = 8'h00;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    out_load = 1'b1;
                    unique case (i_in_item.action)
                        ACT_WRITE: begin
                            mreq.we    = 1'b1;
                            mreq.addr  = i_in_item.mem_address[MEM_AW-1:0];
                            mreq.wdata = i_in_item.mem_data;
                        end
                        ACT_READ: begin
                            out_load  = 1'b0;
                            mreq.re   = 1'b1;
                            mreq.addr = i_in_item.mem_address[MEM_AW-1:0];
                            n_kind    = K_HOST;
                            n_state   = S_RD;
                        end
                        ACT_EXEC: begin
                            if (op[7]) begin
                                status = ST_BAD;
                            end else if (op[6]) begin
                                if (op == OP_HLT) begin
                                    status = ST_HALT;
                                end else if (op[2:0] == RC_M) begin
                                    out_load  = 1'b0;
                                    mreq.re   = 1'b1;
                                    mreq.addr = hl[MEM_AW-1:0];
                                    n_kind    = K_REG;
                                    n_dst     = dst;
                                    n_state   = S_RD;
                                end else if (dst == RC_M) begin
                                    mreq.we    = 1'b1;
                                    mreq.addr  = hl[MEM_AW-1:0];
                                    mreq.wdata = get8(op[2:0]);
                                end else begin
                                    w_en  = 1'b1;
                                    w_val = get8(op[2:0]);
                                end
                            end else begin
                                unique case (op[3:0])
                                    4'h0: begin
                                        if (op != OP_NOP && op != OP_RIM && op != OP_SIM)
                                            status = ST_BAD;
                                    end
                                    4'h8: status = ST_BAD;
                                    4'h1, 4'h3, 4'hB: begin
                                        if (op[3:0] == 4'h1) res16 = imm;
                                        else if (op[3:0] == 4'h3) res16 = pv + 16'd1;
                                        else res16 = pv - 16'd1;
                                        unique case (p)
                                            2'd0: {n_b, n_c} = res16;
                                            2'd1: {n_d, n_e} = res16;
                                            2'd2: {n_h, n_l} = res16;
                                            default: n_sp = res16;
                                        endcase
                                    end
                                    4'h2: begin
                                        if (p[1] == 1'b0) begin
                                            mreq.we    = 1'b1;
                                            mreq.addr  = pv[MEM_AW-1:0];
                                            mreq.wdata = r_a;
                                        end else if (p == 2'd2) begin
                                            // SHLD: L now, H at the next address.
                                            out_load   = 1'b0;
                                            mreq.we    = 1'b1;
                                            mreq.addr  = imm[MEM_AW-1:0];
                                            mreq.wdata = r_l;
                                            n_addr2    = imm[MEM_AW-1:0] + 1'b1;
                                            n_state    = S_WR2;
                                        end else begin
                                            status = ST_BAD;
                                        end
                                    end
                                    4'hA: begin
                                        out_load = 1'b0;
                                        mreq.re  = 1'b1;
                                        n_state  = S_RD;
                                        n_dst    = RC_A;
                                        n_kind   = K_REG;
                                        if (p[1] == 1'b0) begin
                                            mreq.addr = pv[MEM_AW-1:0];
                                        end else begin
                                            mreq.addr = imm[MEM_AW-1:0];
                                            if (p == 2'd2) begin
                                                n_kind  = K_LHLD;
                                                n_addr2 = imm[MEM_AW-1:0] + 1'b1;
                                            end
                                        end
                                    end
                                    4'h4, 4'hC, 4'h5, 4'hD: begin
                                        if (dst == RC_M) begin
                                            out_load  = 1'b0;
                                            mreq.re   = 1'b1;
                                            mreq.addr = hl[MEM_AW-1:0];
                                            n_kind    = K_INR;
                                            n_dec     = op[0];
                                            n_state   = S_RD;
                                        end else begin
                                            {w_val, n_f} = f_incdec(get8(dst), op[0], r_f[0]);
                                            w_en = 1'b1;
                                        end
                                    end
                                    4'h6, 4'hE: begin
                                        if (dst == RC_M) begin
                                            mreq.we    = 1'b1;
                                            mreq.addr  = hl[MEM_AW-1:0];
                                            mreq.wdata = i_in_item.operand_low;
                                        end else begin
                                            w_en  = 1'b1;
                                            w_val = i_in_item.operand_low;
                                        end
                                    end
                                    4'h9: begin
                                        sum = {1'b0, hl} + {1'b0, pv};
                                        {n_h, n_l} = sum[15:0];
                                        n_f[0] = sum[16];
                                    end
                                    4'h7: begin
                                        unique case (p)
                                            2'd0: begin
                                                n_f[0] = r_a[7];
                                                n_a    = {r_a[6:0], r_a[7]};
                                            end
                                            2'd1: begin
                                                n_f[0] = r_a[7];
                                                n_a    = {r_a[6:0], r_f[0]};
                                            end
                                            2'd2: {n_a, n_f} = f_daa(r_a, r_f);
                                            default: n_f[0] = 1'b1;
                                        endcase
                                    end
                                    default: begin
                                        unique case (p)
                                            2'd0: begin
                                                n_f[0] = r_a[0];
                                                n_a    = {r_a[0], r_a[7:1]};
                                            end
                                            2'd1: begin
                                                n_f[0] = r_a[0];
                                                n_a    = {r_f[0], r_a[7:1]};
                                            end
                                            2'd2: n_a = ~r_a;
                                            default: n_f[0] = ~r_f[0];
                                        endcase
                                    end
                                endcase
                            end
                        end
                        default: status = ST_BAD;
                    endcase
                end
            end
            S_RD: begin
                out_load = 1'b1;
                n_state  = S_IDLE;
                unique case (r_kind)
                    K_HOST: rd_val = rdata;
                    K_REG: begin
                        w_en   = 1'b1;
                        w_code = r_dst;
                        w_val  = rdata;
                    end
                    K_INR: begin
                        {mreq.wdata, n_f} = f_incdec(rdata, r_dec, r_f[0]);
                        mreq.we   = 1'b1;
                        mreq.addr = hl[MEM_AW-1:0];
                    end
                    default: begin
                        out_load  = 1'b0;
                        n_l       = rdata;
                        mreq.re   = 1'b1;
                        mreq.addr = r_addr2;
                        n_state   = S_RD2;
                    end
                endcase
            end
            S_RD2: begin
                out_load = 1'b1;
                n_h      = rdata;
                n_state  = S_IDLE;
            end
            default: begin
                out_load   = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_addr2;
                mreq.wdata = r_h;
                n_state    = S_IDLE;
            end
        endcase

        if (w_en) begin
            unique case (w_code)
                3'd0:    n_b = w_val;
                3'd1:    n_c = w_val;
                3'd2:    n_d = w_val;
                3'd3:    n_e = w_val;
                3'd4:    n_h = w_val;
                3'd5:    n_l = w_val;
                RC_A:    n_a = w_val;
                default: ;
            endcase
        end

        n_out.acc           = n_a;
        n_out.flags         = n_f;
        n_out.reg_b         = n_b;
        n_out.reg_c         = n_c;
        n_out.reg_d         = n_d;
        n_out.reg_e         = n_e;
        n_out.reg_h         = n_h;
        n_out.reg_l         = n_l;
        n_out.stack_pointer = n_sp;
        n_out.read_data     = rd_val;
        n_out.status        = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_a <= '0; r_f <= '0; r_b <= '0; r_c <= '0;
            r_d <= '0; r_e <= '0; r_h <= '0; r_l <= '0; r_sp <= '0;
        end else begin
            r_state <= n_state;
            r_a <= n_a; r_f <= n_f; r_b <= n_b; r_c <= n_c;
            r_d <= n_d; r_e <= n_e; r_h <= n_h; r_l <= n_l; r_sp <= n_sp;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (out_load) begin
            r_out <= n_out;
        end
        r_kind  <= n_kind;
        r_dec   <= n_dec;
        r_dst   <= n_dst;
        r_addr2 <= n_addr2;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed instruction, host write, host read and bad-action
// items into the 8085 execute unit; checks every result against a built-in predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import i85x_pkg::*;

    localparam logic [1:0] ACT_BAD = 2'd3;

    class cpu_scoreboard;
        logic [7:0]  a_q;
        logic [7:0]  f_q;
        logic [7:0]  rg[6];
        logic [15:0] sp_q;
        logic [7:0]  mem[MEM_BYTES];
        t_out_item   pending[$];
        int          errors;

        function new();
            a_q = 0; f_q = 0; sp_q = 0; errors = 0;
            foreach (rg[i]) rg[i] = 0;
            foreach (mem[i]) mem[i] = 0;
        endfunction

        function logic [7:0] szp(logic [7:0] v);
            return {v[7], v == 8'h00, 3'b000, ~^v, 2'b00};
        endfunction

        function logic [15:0] hl();
            return {rg[4], rg[5]};
        endfunction

        function logic [7:0] rd_reg(logic [2:0] k);
            if (k == RC_M) return mem[hl() % MEM_BYTES];
            if (k == RC_A) return a_q;
            return rg[k];
        endfunction

        function void wr_reg(logic [2:0] k, logic [7:0] v);
            if (k == RC_M) mem[hl() % MEM_BYTES] = v;
            else if (k == RC_A) a_q = v;
            else rg[k] = v;
        endfunction

        function logic [15:0] rd_pair(logic [1:0] p);
            if (p == 2'd3) return sp_q;
            return {rg[2*p], rg[2*p+1]};
        endfunction

        function void wr_pair(logic [1:0] p, logic [15:0] v);
            if (p == 2'd3) sp_q = v;
            else begin
                rg[2*p] = v[15:8];
                rg[2*p+1] = v[7:0];
            end
        endfunction

        function void step_incdec(logic [2:0] k, bit down);
            logic [7:0] r;
            logic [7:0] v;
            logic       ac;
            r = rd_reg(k);
            v = down ? r - 8'd1 : r + 8'd1;
            ac = down ? (r[3:0] != 0) : (r[3:0] == 4'hF);
            wr_reg(k, v);
            f_q = {f_q[0]} | szp(v) | {3'b000, ac, 4'b0000};
        endfunction

        function void step_daa();
            logic [8:0] t;
            logic       ac;
            logic       cy;
            t = {1'b0, a_q};
            cy = f_q[0];
            ac = 0;
            if (t[3:0] > 9 || f_q[4]) begin
                ac = (t[3:0] > 9);
                t = t + 9'd6;
                if (t[8]) cy = 1;
                t[8] = 0;
            end
            if (t[7:4] > 9 || cy) begin
                t = t + 9'h060;
                if (t[8]) cy = 1;
            end
            a_q = t[7:0];
            f_q = szp(a_q) | {3'b000, ac, 3'b000, cy};
        endfunction

        function logic [1:0] run_op(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
            logic [15:0] imm;
            logic [1:0]  p;
            logic [7:0]  a;
            logic [16:0] s;
            imm = {hi, lo};
            p = op[5:4];
            a = a_q;
            if (op[7]) return ST_BAD;
            if (op[6]) begin
                if (op == OP_HLT) return ST_HALT;
                wr_reg(op[5:3], rd_reg(op[2:0]));
                return ST_OK;
            end
            case (op[3:0])
                4'h0: return (op == OP_NOP || op == OP_RIM || op == OP_SIM) ? ST_OK : ST_BAD;
                4'h8: return ST_BAD;
                4'h1: wr_pair(p, imm);
                4'h2: begin
                    if (p < 2) mem[rd_pair(p) % MEM_BYTES] = a_q;
                    else if (p == 2) begin
                        mem[imm % MEM_BYTES] = rg[5];
                        mem[16'(imm + 16'd1) % MEM_BYTES] = rg[4];
                    end else return ST_BAD;
                end
                4'hA: begin
                    if (p < 2) a_q = mem[rd_pair(p) % MEM_BYTES];
                    else if (p == 2) begin
                        rg[5] = mem[imm % MEM_BYTES];
                        rg[4] = mem[16'(imm + 16'd1) % MEM_BYTES];
                    end else a_q = mem[imm % MEM_BYTES];
                end
                4'h3: wr_pair(p, rd_pair(p) + 16'd1);
                4'hB: wr_pair(p, rd_pair(p) - 16'd1);
                4'h4, 4'hC: step_incdec(op[5:3], 0);
                4'h5, 4'hD: step_incdec(op[5:3], 1);
                4'h6, 4'hE: wr_reg(op[5:3], lo);
                4'h9: begin
                    s = {1'b0, rd_pair(2)} + {1'b0, rd_pair(p)};
                    wr_pair(2, s[15:0]);
                    f_q[0] = s[16];
                end
                4'h7: begin
                    case (p)
                        2'd0: begin f_q[0] = a[7]; a_q = {a[6:0], a[7]}; end
                        2'd1: begin a_q = {a[6:0], f_q[0]}; f_q[0] = a[7]; end
                        2'd2: step_daa();
                        default: f_q[0] = 1;
                    endcase
                end
                default: begin
                    case (p)
                        2'd0: begin f_q[0] = a[0]; a_q = {a[0], a[7:1]}; end
                        2'd1: begin a_q = {f_q[0], a[7:1]}; f_q[0] = a[0]; end
                        2'd2: a_q = ~a;
                        default: f_q[0] = ~f_q[0];
                    endcase
                end
            endcase
            return ST_OK;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            r.read_data = 0;
            r.status = ST_OK;
            if (it.action == ACT_EXEC)
                r.status = run_op(it.opcode, it.operand_low, it.operand_high);
            else if (it.action == ACT_WRITE)
                mem[it.mem_address % MEM_BYTES] = it.mem_data;
            else if (it.action == ACT_READ)
                r.read_data = mem[it.mem_address % MEM_BYTES];
            else
                r.status = ST_BAD;
            r.acc = a_q; r.flags = f_q;
            r.reg_b = rg[0]; r.reg_c = rg[1]; r.reg_d = rg[2];
            r.reg_e = rg[3]; r.reg_h = rg[4]; r.reg_l = rg[5];
            r.stack_pointer = sp_q;
            pending.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t mismatch: expected %h actual %h", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    cpu_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    // Bytes already written, so that no never-written byte is ever read.
    bit written[MEM_BYTES];

    i8085_instruction_execute_unit DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Valid is dropped only in idle cycles, so back-to-back items keep it high.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_input(it);
    endtask

    function automatic bit mem_ok(logic [15:0] ad);
        return written[ad % MEM_BYTES];
    endfunction

    // Predicts which bytes an item would read; returns the first unwritten one in gap.
    function automatic bit safe_item(t_in_item it, output logic [15:0] gap);
        logic [7:0]  op;
        logic [15:0] imm;
        logic [15:0] ad;
        bit          two;
        op = it.opcode;
        imm = {it.operand_high, it.operand_low};
        ad = 16'h0000;
        two = 0;
        gap = 16'h0000;
        if (it.action == ACT_READ) ad = it.mem_address;
        else if (it.action != ACT_EXEC || op[7]) return 1;
        else if (op[6]) begin
            if (op == OP_HLT || op[2:0] != RC_M) return 1;
            ad = sb.hl();
        end else if ((op[3:0] == 4'h4 || op[3:0] == 4'h5 || op[3:0] == 4'hC
                      || op[3:0] == 4'hD) && op[5:3] == RC_M) ad = sb.hl();
        else if (op[3:0] == 4'hA) begin
            if (op[5:4] < 2) ad = sb.rd_pair(op[5:4]);
            else begin
                ad = imm;
                two = (op[5:4] == 2);
            end
        end else return 1;
        if (!mem_ok(ad)) begin
            gap = ad;
            return 0;
        end
        if (two && !mem_ok(ad + 16'd1)) begin
            gap = ad + 16'd1;
            return 0;
        end
        return 1;
    endfunction

    function automatic void mark_writes(t_in_item it);
        logic [7:0]  op;
        logic [15:0] imm;
        op = it.opcode;
        imm = {it.operand_high, it.operand_low};
        if (it.action == ACT_WRITE) written[it.mem_address % MEM_BYTES] = 1;
        if (it.action != ACT_EXEC || op[7]) return;
        if (op[6] && op != OP_HLT && op[5:3] == RC_M) written[sb.hl() % MEM_BYTES] = 1;
        if (!op[6] && (op[3:0] == 4'h6 || op[3:0] == 4'hE) && op[5:3] == RC_M)
            written[sb.hl() % MEM_BYTES] = 1;
        if (!op[6] && op[3:0] == 4'h2) begin
            if (op[5:4] < 2) written[sb.rd_pair(op[5:4]) % MEM_BYTES] = 1;
            else if (op[5:4] == 2) begin
                written[imm % MEM_BYTES] = 1;
                written[16'(imm + 16'd1) % MEM_BYTES] = 1;
            end
        end
    endfunction

    function automatic t_in_item make_exec(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
        t_in_item it;
        it.action = ACT_EXEC; it.opcode = op; it.operand_low = lo; it.operand_high = hi;
        it.mem_address = 16'($urandom()); it.mem_data = 8'($urandom());
        return it;
    endfunction

    function automatic t_in_item make_mem(logic [1:0] act, logic [15:0] ad, logic [7:0] d);
        t_in_item it;
        it = make_exec(8'($urandom()), 8'($urandom()), 8'($urandom()));
        it.action = act; it.mem_address = ad; it.mem_data = d;
        return it;
    endfunction

    task automatic issue(t_in_item it);
        logic [15:0] gap;
        t_in_item    fill;
        // Fill the bytes it reads first, then run it.
        while (!safe_item(it, gap)) begin
            fill = make_mem(ACT_WRITE, gap, 8'($urandom()));
            mark_writes(fill);
            send_item(fill);
        end
        mark_writes(it);
        send_item(it);
    endtask

    // Draws addresses and immediates mostly from a small window, so pointers and H:L tend to hit written bytes.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        logic [15:0] ad;
        pick = $urandom_range(99);
        ad = {$urandom_range(1) ? 8'hFF : 8'h00, 8'($urandom_range(15))};
        if ($urandom_range(9) == 0) ad = 16'($urandom());
        if (pick < 12) it = make_mem(ACT_WRITE, ad, 8'($urandom()));
        else if (pick < 18) it = make_mem(ACT_READ, ad, 8'h00);
        else if (pick < 20) it = make_mem(ACT_BAD, 16'($urandom()), 8'($urandom()));
        else if (pick < 28) it = make_exec({2'b00, 2'($urandom_range(3)), 4'h1},
                                           ad[7:0], ad[15:8]);
        else if (pick < 34) it = make_exec(8'($urandom_range(8'h22, 8'h2A)) & 8'hFA | 8'h22,
                                           ad[7:0], ad[15:8]);
        else if (pick < 95) it = make_exec(8'($urandom_range(8'h7F)), ad[7:0], ad[15:8]);
        else it = make_exec(8'($urandom_range(8'hFF, 8'h80)), 8'($urandom()),
                            8'($urandom()));
        return it;
    endfunction

    initial begin
        t_in_item it;
        sb = new();
        rst_n = 0; in_valid = 0; in_item = '0; out_ready = 0;
        send_idle_pct = 32; recv_idle_pct = 86;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: memory extremes, SHLD and LHLD, a bad action, flag corner cases.
        issue(make_mem(ACT_WRITE, 16'hFFFF, 8'hFF));
        issue(make_mem(ACT_WRITE, 16'h0000, 8'h00));
        issue(make_mem(ACT_READ, 16'hFFFF, 0));
        issue(make_mem(ACT_BAD, 16'h1234, 8'h55));
        issue(make_exec(8'h21, 8'hFF, 8'hFF));   // LXI H,FFFF
        issue(make_exec(8'h22, 8'hFF, 8'hFF));   // SHLD wraps at FFFF
        issue(make_exec(8'h2A, 8'hFF, 8'hFF));   // LHLD
        issue(make_exec(8'h11, 8'h34, 8'h12));   // LXI D byte order
        issue(make_exec(8'h13, 0, 0));           // INX D
        issue(make_exec(8'h31, 8'hFF, 8'hFF));
        issue(make_exec(8'h33, 0, 0));           // SP wraps to zero
        issue(make_exec(8'h3E, 8'h9A, 0));
        issue(make_exec(8'h27, 0, 0));           // DAA with both adjusts
        issue(make_exec(8'h3C, 0, 0));
        issue(make_exec(8'h3E, 8'h0F, 0));
        issue(make_exec(8'h3C, 0, 0));           // INR half carry
        issue(make_exec(8'h3D, 0, 0));
        issue(make_exec(8'h07, 0, 0));
        issue(make_exec(8'h0F, 0, 0));
        issue(make_exec(8'h17, 0, 0));
        issue(make_exec(8'h1F, 0, 0));
        issue(make_exec(8'h29, 0, 0));           // DAD H carry
        issue(make_exec(8'h37, 0, 0));
        issue(make_exec(8'h3F, 0, 0));
        issue(make_exec(OP_HLT, 0, 0));
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 86; recv_idle_pct = 32; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            for (int n = 0; n < 150; n++) issue(random_item());
        end
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0) $display("[i8085_instruction_execute_unit] OK");
        else $display("[i8085_instruction_execute_unit] ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_result(out_item);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("[i8085_instruction_execute_unit] ERROR");
            $finish;
        end
    end

    initial quiet_cycles = 0;
endmodule
